>>> rtl/core/stlb_pkg.sv
// stlb_pkg: shared constants for the set-associative tlb with tree plru
// field widths of the stream words and the operation codes
// no dependencies
package stlb_pkg;

    localparam int SET_IN_W   = 4;
    localparam int PAGE_IN_W  = 36;
    localparam int FRAME_IN_W = 40;
    localparam int FRAME_OUT_W = 40;
    localparam int WAY_OUT_W  = 2;

    // input word: set_index, page_number, frame_in
    localparam int S_TDATA_W = 80;
    // output word: frame_out, way_used, zero fill
    localparam int M_TDATA_W = 48;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_FILL   = 1'b1;

endpackage

>>> rtl/core/set_assoc_tlb_plru_unit.sv
// set_assoc_tlb_plru_unit: set-associative tlb, lookup and fill, tree plru
// uses stlb_pkg, stlb_ram (tag/frame rows and valid/plru rows), stlb_plru
// the result word is registered at the output once the set rows have been read and the output register is free
// a new word is taken only after the previous one has done the read-modify-write of the set row
// the input side is ready again while a finished result still waits at the output
// reset: synchronous active-low; clears control, per-set row flags (valid and plru read zero)
module set_assoc_tlb_plru_unit #(
    parameter int WAYS       = 4,
    parameter int SETS       = 16,
    parameter int PAGE_BITS  = 36,
    parameter int FRAME_BITS = 40
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // set_index[3:0], page_number[39:4], frame_in[79:40]
    input  logic [stlb_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // operation
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // frame_out[39:0], way_used[41:40], zero fill
    output logic [stlb_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // hit
    output logic                           m_axis_tuser
);

    import stlb_pkg::*;

    localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W  = $clog2(WAYS);
    localparam int NODES  = (1 << WAY_W) - 1;
    localparam int ENT_W  = PAGE_BITS + FRAME_BITS;
    localparam int ROW_W  = WAYS * ENT_W;
    localparam int META_W = WAYS + NODES;
    localparam int SET_CODES = 1 << SET_IN_W;

    logic [SET_W-1:0] set_lut [SET_CODES];

    for (genvar g = 0; g < SET_CODES; g++) begin : g_set_lut
        assign set_lut[g] = SET_W'(g % SETS);
    end

    logic                  r_busy;
    logic                  r_row_ok;
    logic                  r_op;
    logic [SET_W-1:0]      r_set;
    logic [PAGE_BITS-1:0]  r_page;
    logic [FRAME_BITS-1:0] r_frame;
    logic [SETS-1:0]       r_row_vld;

    logic                   r_out_vld;
    logic                   r_out_hit;
    logic [FRAME_OUT_W-1:0] r_out_frame;
    logic [WAY_OUT_W-1:0]   r_out_way;

    logic             accept;
    logic             done;
    logic [SET_W-1:0] in_set;

    logic [ROW_W-1:0]  row_rdata;
    logic [META_W-1:0] meta_rdata;
    logic [ROW_W-1:0]  n_row;
    logic [META_W-1:0] n_meta;
    logic              row_we;
    logic              meta_we;

    logic [WAYS-1:0]       vld;
    logic [NODES-1:0]      tree;
    logic [NODES-1:0]      tree_touched;
    logic [WAY_W-1:0]      victim;
    logic [WAYS-1:0]       match;
    logic                  any_match;
    logic [WAY_W-1:0]      hit_way;
    logic [WAY_W-1:0]      free_way;
    logic                  all_vld;
    logic [WAY_W-1:0]      fill_way;
    logic [WAY_W-1:0]      touch_way;
    logic [FRAME_BITS-1:0] hit_frame;
    logic                  is_fill;
    logic [WAY_W-1:0]      res_way;
    logic [WAY_W+1:0]      res_way_ext;

    assign s_axis_tready = ~r_busy;
    assign accept        = s_axis_tvalid & ~r_busy;
    assign done          = r_busy & (~r_out_vld | m_axis_tready);
    assign in_set        = set_lut[s_axis_tdata[SET_IN_W-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_row_vld <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (done) begin
                r_busy <= 1'b0;
            end
            if (meta_we) begin
                r_row_vld[r_set] <= 1'b1;
            end
            if (done) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= s_axis_tuser;
            r_set    <= in_set;
            r_row_ok <= r_row_vld[in_set];
            r_page   <= PAGE_BITS'(s_axis_tdata[SET_IN_W +: PAGE_IN_W]);
            r_frame  <= FRAME_BITS'(s_axis_tdata[SET_IN_W + PAGE_IN_W +: FRAME_IN_W]);
        end
        if (done) begin
            r_out_hit   <= ~is_fill & any_match;
            r_out_frame <= (~is_fill & any_match) ? FRAME_OUT_W'(hit_frame) : '0;
            r_out_way   <= res_way_ext[WAY_OUT_W-1:0];
        end
    end

    stlb_ram #(
        .WIDTH(ROW_W),
        .DEPTH(SETS)
    ) u_row_ram (
        .i_clk  (i_clk),
        .i_we   (row_we),
        .i_waddr(r_set),
        .i_wdata(n_row),
        .i_re   (accept),
        .i_raddr(in_set),
        .o_rdata(row_rdata)
    );

    stlb_ram #(
        .WIDTH(META_W),
        .DEPTH(SETS)
    ) u_meta_ram (
        .i_clk  (i_clk),
        .i_we   (meta_we),
        .i_waddr(r_set),
        .i_wdata(n_meta),
        .i_re   (accept),
        .i_raddr(in_set),
        .o_rdata(meta_rdata)
    );

    // rows never written since reset read as all invalid, tree zero
    assign vld     = r_row_ok ? meta_rdata[WAYS-1:0] : '0;
    assign tree    = r_row_ok ? meta_rdata[META_W-1:WAYS] : '0;
    assign is_fill = (r_op == OP_FILL);

    stlb_plru #(
        .WAYS(WAYS)
    ) u_plru (
        .i_tree  (tree),
        .i_way   (touch_way),
        .o_tree  (tree_touched),
        .o_victim(victim)
    );

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            match[w] = vld[w] && (row_rdata[w*ENT_W +: PAGE_BITS] == r_page);
        end
        any_match = |match;
        all_vld   = &vld;
        hit_way   = '0;
        free_way  = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                hit_way = WAY_W'(w);
            end
            if (!vld[w]) begin
                free_way = WAY_W'(w);
            end
        end
        hit_frame = row_rdata[hit_way*ENT_W + PAGE_BITS +: FRAME_BITS];
        fill_way  = all_vld ? victim : free_way;
        touch_way = is_fill ? fill_way : hit_way;
        res_way   = is_fill ? fill_way : (any_match ? hit_way : '0);
        res_way_ext = (WAY_W + 2)'(res_way);
    end

    always_comb begin
        n_row = row_rdata;
        n_row[fill_way*ENT_W +: ENT_W] = {r_frame, r_page};
        n_meta = {tree_touched, vld};
        if (is_fill) begin
            n_meta[fill_way] = 1'b1;
        end
        row_we  = done & is_fill;
        meta_we = done & (is_fill | any_match);
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out_hit;
    assign m_axis_tdata  = M_TDATA_W'({r_out_way, r_out_frame});

endmodule

>>> rtl/core/stlb_ram.sv
// stlb_ram: generic single-clock ram, one write port and one read port
// read data registered, held while read enable is low
// no dependencies
module stlb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/stlb_plru.sv
// stlb_plru: tree pseudo-lru update and victim selection for one set
// heap-ordered node bits, node 1 at bit 0; 0 points to the lower half
// no dependencies
module stlb_plru #(
    parameter int WAYS = 4,
    parameter int LV = $clog2(WAYS),
    parameter int NODES = (1 << LV) - 1
) (
    input  logic [NODES-1:0] i_tree,
    input  logic [LV-1:0]    i_way,
    output logic [NODES-1:0] o_tree,
    output logic [LV-1:0]    o_victim
);

    // touch: point every node on the path away from the used way
    always_comb begin
        logic [LV:0]   node;
        logic [LV:0]   node_m1;
        logic          dir;
        node   = (LV + 1)'(1);
        o_tree = i_tree;
        for (int i = 0; i < LV; i++) begin
            dir     = i_way[LV-1-i];
            node_m1 = node - (LV + 1)'(1);
            o_tree[node_m1[LV-1:0]] = ~dir;
            node    = {node[LV-1:0], dir};
        end
    end

    // victim: follow the node bits from the root
    always_comb begin
        logic [LV:0]   node;
        logic [LV:0]   node_m1;
        logic [LV-1:0] way;
        logic          dir;
        node = (LV + 1)'(1);
        way  = '0;
        for (int i = 0; i < LV; i++) begin
            node_m1 = node - (LV + 1)'(1);
            dir     = i_tree[node_m1[LV-1:0]];
            way     = LV'({way, dir});
            node    = {node[LV-1:0], dir};
        end
        if ({1'b0, way} >= (LV + 1)'(WAYS)) begin
            way = LV'(WAYS - 1);
        end
        o_victim = way;
    end

endmodule
